@@ hw/rtl/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MET_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define MET_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ hw/rtl/met_pkg.sv @@
package met_pkg;

    localparam int COUNT_WIDTH_DEF  = 20;
    localparam int LOG_FRAC_DEF     = 16;
    localparam int NUM_BINS         = 256;
    localparam logic [7:0] WHITE_LEVEL = 8'd255;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam logic ACTION_ACCUMULATE = 1'b0;
    localparam logic ACTION_BINARIZE   = 1'b1;
    localparam logic KIND_PIXEL        = 1'b0;
    localparam logic KIND_REPORT       = 1'b1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_ACC_WR,
        S_LN_RD,
        S_LN_GO,
        S_LN_START,
        S_LN_WAIT,
        S_T_BEGIN,
        S_T_LO_ST,
        S_T_LO_W,
        S_T_HI_ST,
        S_T_HI_W,
        S_TM_RD,
        S_TM_CHK,
        S_TM_MUL,
        S_TM_DIV,
        S_TM_ACC,
        S_T_END,
        S_CLR
    } state_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQR,
        LN_MUL
    } ln_state_t;

endpackage

@@ hw/rtl/met_ram.sv @@
module met_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/met_ln_unit.sv @@
module met_ln_unit #(
    parameter int SUM_WIDTH = 28,
    parameter int FRAC_BITS = 16,
    localparam int KW = (SUM_WIDTH > 32) ? $clog2(SUM_WIDTH) : 5,
    localparam int LW = KW + FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SUM_WIDTH-1:0] x,
    output logic                 done,
    output logic [LW-1:0]        ln
);
    import met_pkg::*;

    localparam int CNW = $clog2(FRAC_BITS + 1);

    ln_state_t state_reg, state_next;
    logic [63:0] m_reg, m_next;
    logic [KW-1:0] k_reg, k_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] ln_reg, ln_next;
    logic done_reg, done_next;
    logic [63:0] sq;
    logic [LW+31:0] lmul;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        k_reg    <= k_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
        ln_reg   <= ln_next;
    end

    always_comb
    begin
        sq   = m_reg[31:0] * m_reg[31:0];
        lmul = (LW + 32)'({k_reg, frac_reg}) * (LW + 32)'(LN2_Q32);
        state_next = state_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        ln_next    = ln_reg;
        done_next  = 1'b0;
        case (state_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    if (x == '0)
                    begin
                        ln_next   = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        m_next     = 64'(x);
                        k_next     = KW'(31);
                        state_next = LN_NORM;
                    end
                end
            end
            LN_NORM:
            begin
                if (m_reg[63:32] != '0)
                begin
                    m_next = m_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!m_reg[31])
                begin
                    m_next = m_reg << 1;
                    k_next = k_reg - KW'(1);
                end
                else
                begin
                    cnt_next   = '0;
                    frac_next  = '0;
                    state_next = LN_SQR;
                end
            end
            LN_SQR:
            begin
                frac_next = {frac_reg[FRAC_BITS-2:0], sq[63]};
                if (sq[63])
                begin
                    m_next = {32'b0, sq[63:32]};
                end
                else
                begin
                    m_next = {32'b0, sq[62:31]};
                end
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(FRAC_BITS - 1))
                begin
                    state_next = LN_MUL;
                end
            end
            LN_MUL:
            begin
                ln_next    = lmul[LW+31:32];
                done_next  = 1'b1;
                state_next = LN_IDLE;
            end
            default:
            begin
                state_next = LN_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign ln   = ln_reg;

endmodule

@@ hw/rtl/max_entropy_threshold_unit.sv @@
// Maximum-entropy grey-level threshold unit. A command is taken when start is high and busy
// is low; a result shows for one cycle with result_valid and cannot be held off. After reset
// the unit stays busy for a sweep that clears all 256 bins of the histogram memory. Binarize
// commands answer in the cycle after they are taken. Accumulate commands do a
// read-modify-write of the histogram memory, reading in S_IDLE and writing back in S_ACC_WR.
// The last accumulate of a frame starts the search: a log pass over 256 bins with the
// iterative log unit, then for each of the 256 thresholds two log evaluations and, for
// every nonzero bin, a multiply and a bit-serial divide; finally a clearing sweep of the
// histogram's 256 bins, at whose end the threshold report is issued.
module max_entropy_threshold_unit #(
    parameter int COUNT_WIDTH       = met_pkg::COUNT_WIDTH_DEF,
    parameter int LOG_FRACTION_BITS = met_pkg::LOG_FRAC_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] pixel_value,
    input  logic       frame_last,
    output logic       result_valid,
    output logic       result_kind,
    output logic [7:0] pixel_out,
    output logic [7:0] threshold_out
);
    import met_pkg::*;
    `include "assert_macros.svh"

    localparam int SW  = COUNT_WIDTH + 8;
    localparam int KW  = (SW > 32) ? $clog2(SW) : 5;
    localparam int LW  = KW + LOG_FRACTION_BITS;
    localparam int PW  = COUNT_WIDTH + LW;
    localparam int ACW = LW + 9;
    localparam int DCW = $clog2(PW + 1);

    state_t state_reg, state_next;
    logic [7:0] i_reg, i_next, t_reg, t_next;
    logic [7:0] thr_reg, thr_next, best_t_reg, best_t_next;
    logic [31:0] best_reg, best_next;
    logic [SW-1:0] total_reg, total_next, s_lo_reg, s_lo_next, x_reg, x_next;
    logic [SW-1:0] div_reg, div_next;
    logic [COUNT_WIDTH-1:0] h_reg, h_next, ht_reg, ht_next;
    logic [LW-1:0] d_reg, d_next, lns_lo_reg, lns_lo_next, lns_hi_reg, lns_hi_next;
    logic [PW-1:0] q_reg, q_next;
    logic [SW:0] rem_reg, rem_next, rem_sh;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic [ACW-1:0] acc_reg, acc_next;
    logic rv_reg, rv_next, rk_reg, rk_next;
    logic [7:0] po_reg, po_next;
    logic [7:0] pix_reg, pix_next;
    logic last_reg, last_next;

    logic hist_we, lnh_we, ln_start, ln_done;
    logic [7:0] hist_waddr, hist_raddr;
    logic [COUNT_WIDTH-1:0] hist_wdata, hist_rdata;
    logic [LW-1:0] lnh_rdata, ln_res, lns_sel;
    logic [SW-1:0] s_sel;
    logic [63:0] acc_ext;
    logic [31:0] score;
    logic accept;

    met_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    met_ram #(.WIDTH(LW), .DEPTH(NUM_BINS)) u_lnh (
        .clk   (clk),
        .we    (lnh_we),
        .waddr (i_reg),
        .wdata (ln_res),
        .raddr (i_reg),
        .rdata (lnh_rdata)
    );

    met_ln_unit #(.SUM_WIDTH(SW), .FRAC_BITS(LOG_FRACTION_BITS)) u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .x     (x_reg),
        .done  (ln_done),
        .ln    (ln_res)
    );

    assign accept = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            i_reg     <= '0;
            rv_reg    <= 1'b0;
            thr_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            rv_reg    <= rv_next;
            thr_reg   <= thr_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        best_t_reg <= best_t_next;
        total_reg  <= total_next;
        s_lo_reg   <= s_lo_next;
        x_reg      <= x_next;
        div_reg    <= div_next;
        h_reg      <= h_next;
        ht_reg     <= ht_next;
        d_reg      <= d_next;
        lns_lo_reg <= lns_lo_next;
        lns_hi_reg <= lns_hi_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        rk_reg     <= rk_next;
        po_reg     <= po_next;
        pix_reg    <= pix_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        t_next      = t_reg;
        thr_next    = thr_reg;
        best_next   = best_reg;
        best_t_next = best_t_reg;
        total_next  = total_reg;
        s_lo_next   = s_lo_reg;
        x_next      = x_reg;
        div_next    = div_reg;
        h_next      = h_reg;
        ht_next     = ht_reg;
        d_next      = d_reg;
        lns_lo_next = lns_lo_reg;
        lns_hi_next = lns_hi_reg;
        q_next      = q_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        rv_next     = 1'b0;
        rk_next     = rk_reg;
        po_next     = po_reg;
        pix_next    = pix_reg;
        last_next   = last_reg;
        hist_we     = 1'b0;
        hist_waddr  = pix_reg;
        hist_wdata  = '0;
        hist_raddr  = i_reg;
        lnh_we      = 1'b0;
        ln_start    = 1'b0;
        rem_sh      = {rem_reg[SW-1:0], q_reg[PW-1]};
        if (i_reg < t_reg)
        begin
            lns_sel = lns_lo_reg;
            s_sel   = s_lo_reg;
        end
        else
        begin
            lns_sel = lns_hi_reg;
            s_sel   = total_reg - s_lo_reg;
        end
        acc_ext = 64'(acc_reg);
        score   = (acc_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_ext[31:0];
        case (state_reg)
            S_INIT:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg;
                i_next     = i_reg + 8'd1;
                if (i_reg == 8'd255)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                hist_raddr = pixel_value;
                if (accept)
                begin
                    if (action == ACTION_BINARIZE)
                    begin
                        rv_next = 1'b1;
                        rk_next = KIND_PIXEL;
                        po_next = (pixel_value > thr_reg) ? WHITE_LEVEL : 8'd0;
                    end
                    else
                    begin
                        pix_next   = pixel_value;
                        last_next  = frame_last;
                        state_next = S_ACC_WR;
                    end
                end
            end
            S_ACC_WR:
            begin
                hist_we    = 1'b1;
                hist_wdata = (&hist_rdata) ? hist_rdata : hist_rdata + COUNT_WIDTH'(1);
                if (last_reg)
                begin
                    i_next     = '0;
                    total_next = '0;
                    state_next = S_LN_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LN_RD:
            begin
                state_next = S_LN_GO;
            end
            S_LN_GO:
            begin
                x_next     = SW'(hist_rdata);
                total_next = total_reg + SW'(hist_rdata);
                state_next = S_LN_START;
            end
            S_LN_START:
            begin
                ln_start   = 1'b1;
                state_next = S_LN_WAIT;
            end
            S_LN_WAIT:
            begin
                if (ln_done)
                begin
                    lnh_we = 1'b1;
                    i_next = i_reg + 8'd1;
                    if (i_reg == 8'd255)
                    begin
                        t_next      = '0;
                        s_lo_next   = '0;
                        best_next   = '0;
                        best_t_next = '0;
                        state_next  = S_T_BEGIN;
                    end
                    else
                    begin
                        state_next = S_LN_RD;
                    end
                end
            end
            S_T_BEGIN:
            begin
                x_next     = s_lo_reg;
                acc_next   = '0;
                state_next = S_T_LO_ST;
            end
            S_T_LO_ST:
            begin
                ln_start   = 1'b1;
                state_next = S_T_LO_W;
            end
            S_T_LO_W:
            begin
                if (ln_done)
                begin
                    lns_lo_next = ln_res;
                    x_next      = total_reg - s_lo_reg;
                    state_next  = S_T_HI_ST;
                end
            end
            S_T_HI_ST:
            begin
                ln_start   = 1'b1;
                state_next = S_T_HI_W;
            end
            S_T_HI_W:
            begin
                if (ln_done)
                begin
                    lns_hi_next = ln_res;
                    i_next      = '0;
                    state_next  = S_TM_RD;
                end
            end
            S_TM_RD:
            begin
                state_next = S_TM_CHK;
            end
            S_TM_CHK:
            begin
                if (i_reg == t_reg)
                begin
                    ht_next = hist_rdata;
                end
                if (hist_rdata == '0)
                begin
                    state_next = S_TM_ACC;
                    q_next     = '0;
                end
                else
                begin
                    h_next     = hist_rdata;
                    d_next     = (lns_sel >= lnh_rdata) ? lns_sel - lnh_rdata : '0;
                    div_next   = s_sel;
                    state_next = S_TM_MUL;
                end
            end
            S_TM_MUL:
            begin
                q_next     = PW'(h_reg) * PW'(d_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_TM_DIV;
            end
            S_TM_DIV:
            begin
                if (rem_sh >= {1'b0, div_reg})
                begin
                    rem_next = rem_sh - {1'b0, div_reg};
                    q_next   = {q_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + DCW'(1);
                if (cnt_reg == DCW'(PW - 1))
                begin
                    state_next = S_TM_ACC;
                end
            end
            S_TM_ACC:
            begin
                acc_next = acc_reg + ACW'(q_reg);
                i_next   = i_reg + 8'd1;
                if (i_reg == 8'd255)
                begin
                    state_next = S_T_END;
                end
                else
                begin
                    state_next = S_TM_RD;
                end
            end
            S_T_END:
            begin
                if (score > best_reg)
                begin
                    best_next   = score;
                    best_t_next = t_reg;
                end
                s_lo_next = s_lo_reg + SW'(ht_reg);
                t_next    = t_reg + 8'd1;
                if (t_reg == 8'd255)
                begin
                    i_next     = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_T_BEGIN;
                end
            end
            S_CLR:
            begin
                hist_we    = 1'b1;
                hist_waddr = i_reg;
                i_next     = i_reg + 8'd1;
                if (i_reg == 8'd255)
                begin
                    thr_next   = best_t_reg;
                    rv_next    = 1'b1;
                    rk_next    = KIND_REPORT;
                    po_next    = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = rv_reg;
    assign result_kind   = rk_reg;
    assign pixel_out     = po_reg;
    assign threshold_out = thr_reg;

    `MET_ASSERT_IMP(a_pixel_src, clk, rst_n, result_valid && (result_kind == KIND_PIXEL), $past(start && !busy && (action == ACTION_BINARIZE)), "pixel result without binarize transfer")
    `MET_ASSERT_NXT(a_acc_busy, clk, rst_n, start && !busy && (action == ACTION_ACCUMULATE), busy, "accumulate transfer did not raise busy")
    `MET_ASSERT_IMP(a_report_src, clk, rst_n, result_valid && (result_kind == KIND_REPORT), $past(state_reg == S_CLR) && (pixel_out == 8'd0), "report outside clearing sweep end")

endmodule
